### rtl/telemetry_frame_parser_assert.svh
// Assertion macros shared by the telemetry frame parser RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef TELEMETRY_FRAME_PARSER_ASSERT_SVH
`define TELEMETRY_FRAME_PARSER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define TFP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define TFP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define TFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tfp_pkg.sv
// Types and constants for the telemetry frame parser.
// Used by tfp_frame_check, telemetry_frame_parser and the testbench files; depends on nothing.
package tfp_pkg;

  localparam int STORE_DEPTH = 13;
  localparam int POS_W       = $clog2(STORE_DEPTH + 1);

  localparam logic [POS_W-1:0] BATT_LEN = POS_W'(9);
  localparam logic [POS_W-1:0] VEL_LEN  = POS_W'(13);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(STORE_DEPTH - 1);

  localparam logic [7:0] BATT_HEAD = 8'd20;
  localparam logic [7:0] BATT_TAIL = 8'd21;
  localparam logic [7:0] VEL_HEAD  = 8'd18;
  localparam logic [7:0] VEL_TAIL  = 8'd19;

  typedef enum logic [1:0] {
    STATUS_BATTERY        = 2'd0,
    STATUS_VELOCITY       = 2'd1,
    STATUS_CHECKSUM_ERROR = 2'd2
  } tfp_status_t;

  typedef logic [STORE_DEPTH-1:0][7:0] tfp_frame_t;

  typedef struct packed {
    tfp_status_t status;
    logic [7:0]  robot;
    logic [31:0] first;
    logic [31:0] second;
  } tfp_result_t;

  typedef struct packed {
    logic        hit;      // a recognised frame has completed
    logic        restart;  // collection starts again at position 0
    tfp_result_t result;
  } tfp_check_t;

endpackage

### rtl/tfp_frame_check.sv
// Frame recognition and checksum comparison for the telemetry frame parser.
// Depends on tfp_pkg; purely combinational.
module tfp_frame_check (
  input  tfp_pkg::tfp_frame_t        frame,
  input  logic [tfp_pkg::POS_W-1:0]  count,
  output tfp_pkg::tfp_check_t        check
);
  import tfp_pkg::*;

  logic [15:0] batt_sum;
  logic [15:0] vel_sum;
  logic [15:0] batt_expect;
  logic [15:0] vel_expect;
  logic        batt_ok;
  logic        vel_ok;
  logic [31:0] word_lo;
  logic [31:0] word_hi;

  // The sums never exceed eleven bits, so the 16-bit wrap never comes into play.
  assign batt_sum = 16'(frame[2]) + 16'(frame[3]) + 16'(frame[4]) + 16'(frame[5]);
  assign vel_sum  = batt_sum + 16'(frame[6]) + 16'(frame[7]) + 16'(frame[8]) + 16'(frame[9]);

  assign batt_expect = {frame[7], frame[6]};
  assign vel_expect  = {frame[11], frame[10]};
  assign batt_ok     = (batt_sum == batt_expect);
  assign vel_ok      = (vel_sum == vel_expect);

  assign word_lo = {frame[5], frame[4], frame[3], frame[2]};
  assign word_hi = {frame[9], frame[8], frame[7], frame[6]};

  always_comb begin
    check               = '0;
    check.result.robot  = frame[1];
    check.result.status = STATUS_CHECKSUM_ERROR;
    if (count == BATT_LEN) begin
      if (frame[0] == BATT_HEAD && frame[BATT_LEN-1] == BATT_TAIL) begin
        check.hit     = 1'b1;
        check.restart = 1'b1;
        if (batt_ok) begin
          check.result.status = STATUS_BATTERY;
          check.result.first  = word_lo;
        end
      end
    end else if (count == VEL_LEN) begin
      // An unmatched full-length frame is dropped and collection restarts.
      check.restart = 1'b1;
      if (frame[0] == VEL_HEAD && frame[VEL_LEN-1] == VEL_TAIL) begin
        check.hit = 1'b1;
        if (vel_ok) begin
          check.result.status = STATUS_VELOCITY;
          check.result.first  = word_lo;
          check.result.second = word_hi;
        end
      end
    end
  end

endmodule

### rtl/telemetry_frame_parser.sv
// Telemetry frame parser top level: frame store, byte position and result buffer.
// Depends on tfp_pkg, tfp_frame_check and telemetry_frame_parser_assert.svh.
//
// The parser takes one received serial byte per clock cycle while rx_ready is
// high and gathers bytes into a 13-byte frame store. A 9-byte frame framed by
// 20 and 21 is a battery frame, a 13-byte frame framed by 18 and 19 is a
// wheel-velocity frame; each yields one result word with the robot number, the
// raw float words and a status (battery valid, velocity valid or checksum
// mismatch, in which case both words are zero). A 13-byte frame that matches
// neither is dropped and collection restarts. The checksum is computed as the
// closing byte arrives, so the result is registered as that byte is taken. The
// output has a two-word buffer: input bytes keep flowing while one result
// waits, and rx_ready falls only while two results are held undelivered.
`include "telemetry_frame_parser_assert.svh"

module telemetry_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  frame_status,
  output logic [7:0]  robot_number,
  output logic [31:0] first_word,
  output logic [31:0] second_word
);
  import tfp_pkg::*;

  tfp_frame_t       frame_store;
  tfp_frame_t       frame_view;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] count;
  tfp_check_t       check;
  tfp_result_t      result;
  tfp_result_t      skid;
  logic             skid_valid;
  logic             accept;
  logic             hit;

  assign rx_ready = !skid_valid;
  assign accept   = rx_valid && rx_ready;
  assign hit      = accept && check.hit;
  assign count    = position + POS_W'(1);

  // The frame as it stands once the incoming word has been written.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      frame_view[i] = (position == POS_W'(i)) ? rx_byte : frame_store[i];
    end
  end

  tfp_frame_check u_check (
    .frame (frame_view),
    .count (count),
    .check (check)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_store[position[POS_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= check.restart ? '0 : count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result       <= skid;
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= hit;
        if (hit) begin
          result <= check.result;
        end
      end
    end else if (hit) begin
      skid       <= check.result;
      skid_valid <= 1'b1;
    end
  end

  assign frame_status = result.status;
  assign robot_number = result.robot;
  assign first_word   = result.first;
  assign second_word  = result.second;

  `TFP_ASSERT_ALWAYS(a_position_range, position <= LAST_POS, "byte position beyond frame store")
  `TFP_ASSERT_IMPLIES(a_skid_behind_out, skid_valid, result_valid, "skid word held with empty output")
  `TFP_ASSERT_NEXT(a_hit_delivered, hit, result_valid, "recognised frame produced no result")
  `TFP_ASSERT_IMPLIES(a_battery_second_zero, result_valid && frame_status == STATUS_BATTERY, second_word == 32'd0, "battery result with non-zero second word")
  `TFP_ASSERT_IMPLIES(a_error_words_zero, result_valid && frame_status == STATUS_CHECKSUM_ERROR, first_word == 32'd0 && second_word == 32'd0, "checksum error with non-zero words")

endmodule

### dv/frame_result_checker.sv
// Result checker for the telemetry frame parser: predicts each frame result from the input words.
// Depends on tfp_pkg for the status codes, frame markers, frame lengths and the result layout.
`timescale 1ns / 100ps

module frame_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_ready,
  input  logic [7:0]  rx_byte,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [1:0]  frame_status,
  input  logic [7:0]  robot_number,
  input  logic [31:0] first_word,
  input  logic [31:0] second_word,
  output int          fail_count,
  output int          outstanding
);
  import tfp_pkg::*;

  logic [7:0]  frame_bytes [STORE_DEPTH];
  logic [3:0]  fill_pos;
  tfp_result_t due_frames [$];

  function automatic logic [31:0] le_word(input int at);
    return {frame_bytes[at + 3], frame_bytes[at + 2], frame_bytes[at + 1], frame_bytes[at]};
  endfunction

  function automatic logic checksum_ok(input int first, input int last, input int sum_at);
    logic [15:0] sum;
    sum = '0;
    for (int k = first; k <= last; k++) sum += frame_bytes[k];
    return sum == {frame_bytes[sum_at + 1], frame_bytes[sum_at]};
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    tfp_result_t r;
    logic        ok;
    int          pos;
    pos = fill_pos;
    if (pos >= STORE_DEPTH) pos = 0;
    frame_bytes[pos] = b;
    pos++;
    fill_pos = 4'(pos);
    if (pos == BATT_LEN) begin
      if (frame_bytes[0] == BATT_HEAD && frame_bytes[BATT_LEN - 1] == BATT_TAIL) begin
        ok       = checksum_ok(2, 5, 6);
        r.status = ok ? STATUS_BATTERY : STATUS_CHECKSUM_ERROR;
        r.robot  = frame_bytes[1];
        r.first  = ok ? le_word(2) : '0;
        r.second = '0;
        due_frames.insert(due_frames.size(), r);
        fill_pos = '0;
      end
    end else if (pos == VEL_LEN) begin
      // A full-length frame always restarts collection, recognised or not.
      fill_pos = '0;
      if (frame_bytes[0] == VEL_HEAD && frame_bytes[VEL_LEN - 1] == VEL_TAIL) begin
        ok       = checksum_ok(2, 9, 10);
        r.status = ok ? STATUS_VELOCITY : STATUS_CHECKSUM_ERROR;
        r.robot  = frame_bytes[1];
        r.first  = ok ? le_word(2) : '0;
        r.second = ok ? le_word(6) : '0;
        due_frames.insert(due_frames.size(), r);
      end
    end
  endtask

  task automatic compare_frame_result();
    tfp_result_t want;
    if (due_frames.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected frame result: status %0d robot %0d first %h second %h",
                 frame_status, robot_number, first_word, second_word);
    end else begin
      want = due_frames.pop_front();
      if (frame_status !== want.status || robot_number !== want.robot ||
          first_word !== want.first || second_word !== want.second) begin
        fail_count++;
        if (fail_count <= 10)
          $display("frame result differs: expected %0d %0d %h %h, got %0d %0d %h %h",
                   want.status, want.robot, want.first, want.second,
                   frame_status, robot_number, first_word, second_word);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_frames.delete();
      fill_pos   = '0;
      fail_count = 0;
    end else begin
      // The result word leaving now belongs to an earlier frame, so it is checked first.
      if (result_valid && result_ready) compare_frame_result();
      if (rx_valid && rx_ready) parse_rx_byte(rx_byte);
    end
    outstanding <= due_frames.size();
  end

endmodule

### dv/testbench.sv
// Top of the telemetry frame parser testbench: clock, reset, byte stimulus, result back-pressure.
// Depends on tfp_pkg, telemetry_frame_parser and frame_result_checker.
`timescale 1ns / 100ps

module testbench;
  import tfp_pkg::*;

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        result_valid;
  logic        result_ready;
  logic [1:0]  frame_status;
  logic [7:0]  robot_number;
  logic [31:0] first_word;
  logic [31:0] second_word;
  int          fail_count;
  int          outstanding;

  logic [7:0]  frame_buf [STORE_DEPTH];
  int          align_pos;
  logic [7:0]  align_head;
  int          bytes_sent;

  telemetry_frame_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .frame_status (frame_status),
    .robot_number (robot_number),
    .first_word   (first_word),
    .second_word  (second_word)
  );

  frame_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .frame_status (frame_status),
    .robot_number (robot_number),
    .first_word   (first_word),
    .second_word  (second_word),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // A quarter of the draws pick one of the frame markers, so that stray heads and tails turn up.
  function automatic logic [7:0] noisy_byte();
    if ($urandom_range(0, 3) == 0) return 8'(VEL_HEAD + $urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    @(negedge clk);
    // Track where the parser stands in its frame, so that noise can be followed by a resync.
    if (align_pos == 0) align_head = b;
    align_pos++;
    if ((align_pos == BATT_LEN && align_head == BATT_HEAD && b == BATT_TAIL) ||
        align_pos == VEL_LEN)
      align_pos = 0;
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit burst);
    for (int i = 0; i < len; i++) send_byte(frame_buf[i], burst);
  endtask

  initial begin
    int          hold;
    int          calm_results;
    calm_results = 0;
    result_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (calm_results == 0 && $urandom_range(0, 7) == 0) calm_results = $urandom_range(5, 30);
      hold = (calm_results > 0) ? 0 : $urandom_range(0, 14);
      if (calm_results > 0) calm_results--;
      if (hold > 0) begin
        result_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  initial begin
    int          choice;
    int          len;
    int          sum_at;
    int          pick;
    int          count;
    bit          velocity;
    bit          burst;
    logic [15:0] sum;

    rst        = 1'b1;
    rx_valid   = 1'b0;
    rx_byte    = '0;
    align_pos  = 0;
    align_head = '0;
    bytes_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Battery frame with every field at its maximum; the checksum is 4 x 255.
    frame_buf[0] = BATT_HEAD;
    for (int i = 1; i < 6; i++) frame_buf[i] = 8'hFF;
    frame_buf[6] = 8'hFC;
    frame_buf[7] = 8'h03;
    frame_buf[8] = BATT_TAIL;
    send_frame(BATT_LEN, 1'b0);

    // Velocity frame for robot zero with a zero payload and a checksum one too high.
    frame_buf[0] = VEL_HEAD;
    for (int i = 1; i < 10; i++) frame_buf[i] = 8'h00;
    frame_buf[10] = 8'h01;
    frame_buf[11] = 8'h00;
    frame_buf[12] = VEL_TAIL;
    send_frame(VEL_LEN, 1'b1);

    // Battery head without its tail: collection runs on to 13 bytes and the frame is dropped.
    frame_buf[0] = BATT_HEAD;
    for (int i = 1; i < 13; i++) frame_buf[i] = 8'h5A;
    frame_buf[8]  = VEL_TAIL;
    frame_buf[12] = VEL_TAIL;
    send_frame(VEL_LEN, 1'b0);

    while (bytes_sent < 1250) begin
      choice = $urandom_range(0, 99);
      burst  = ($urandom_range(0, 3) == 0);
      if (choice < 88 && choice >= 76) begin
        count = $urandom_range(1, 20);
        for (int i = 0; i < count; i++) send_byte(noisy_byte(), burst);
      end else begin
        velocity = $urandom_range(0, 1);
        len      = velocity ? VEL_LEN : BATT_LEN;
        sum_at   = velocity ? 10 : 6;
        frame_buf[0] = velocity ? VEL_HEAD : BATT_HEAD;
        frame_buf[1] = 8'($urandom_range(0, 255));
        sum = '0;
        for (int k = 2; k < sum_at; k++) begin
          frame_buf[k] = 8'($urandom_range(0, 255));
          sum += frame_buf[k];
        end
        {frame_buf[sum_at + 1], frame_buf[sum_at]} = sum;
        frame_buf[len - 1] = velocity ? VEL_TAIL : BATT_TAIL;
        if (choice < 76) begin
          // One frame in five carries a damaged payload or checksum word.
          if ($urandom_range(0, 4) == 0) begin
            pick = $urandom_range(2, sum_at + 1);
            frame_buf[pick] ^= 8'($urandom_range(1, 255));
          end
        end else if ($urandom_range(0, 1) == 0) begin
          frame_buf[len - 1] ^= 8'($urandom_range(1, 255));
        end else begin
          len = $urandom_range(3, len - 1);
        end
        send_frame(len, burst);
      end
      // Mostly bring the parser back to the start of a frame; sometimes leave it out of step.
      if ($urandom_range(0, 3) != 0)
        while (align_pos != 0) send_byte(noisy_byte(), burst);
    end

    rx_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
